// ===== src/trial_division_prime_test_macros.svh =====
// Assertion macros for the prime test RTL.
// No dependencies; taken in by `include inside tdpt_ctrl, the one module that asserts.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tdpt_pkg.sv =====
// Package for the trial-division prime test: controller states, command and
// status bundles between controller and datapath, default width.
`timescale 1ns / 1ps

package tdpt_pkg;

	localparam int DEF_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCREEN,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} tdpt_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture candidate, divisor := 3
		logic div_init;    // start a remainder run on the current divisor
		logic div_step;    // one restoring-division bit
		logic next_div;    // divisor += 2 and restart the remainder run
		logic set_verdict; // write the result flag
		logic verdict;
	} tdpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic n_lt2;
		logic n_eq2;
		logic n_even;
		logic last_step;   // final division bit this cycle
		logic d_gt_q;      // divisor above quotient: d*d > n, nothing left to try
		logic rem_zero;
	} tdpt_sts_t;

endpackage

// ===== src/tdpt_dpath.sv =====
// Datapath of the prime test: candidate and divisor registers, a one-bit-per-
// cycle restoring divider and the result flag. Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_dpath #(
	parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] candidate,
	input  tdpt_pkg::tdpt_cmd_t cmd,
	output tdpt_pkg::tdpt_sts_t sts,
	output logic             is_prime
);
	import tdpt_pkg::*;

	localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             prime_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	// shift in the next dividend bit and try to subtract the divisor
	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = ~diff[WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= candidate;
			d_q <= WIDTH'(3);
		end else if (cmd.next_div) begin
			d_q <= d_q + WIDTH'(2);
		end
		if (cmd.div_init || cmd.next_div) begin
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= CW'(WIDTH - 1);
		end else if (cmd.div_step) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= 1'b0;
		end else if (cmd.set_verdict) begin
			prime_q <= cmd.verdict;
		end
	end

	always_comb begin
		sts.n_lt2     = (n_q[WIDTH-1:1] == '0);
		sts.n_eq2     = (n_q == WIDTH'(2));
		sts.n_even    = ~n_q[0];
		sts.last_step = (cnt_q == '0);
		sts.d_gt_q    = (d_q > quo_q);
		sts.rem_zero  = (rem_q == '0);
	end

	assign is_prime = prime_q;

endmodule

// ===== src/tdpt_ctrl.sv =====
// Controller of the prime test: sequences screening, division runs and the
// result beat. Depends on tdpt_pkg and trial_division_prime_test_macros.svh.
`timescale 1ns / 1ps

module tdpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tdpt_pkg::tdpt_sts_t sts,
	output tdpt_pkg::tdpt_cmd_t cmd,
	output logic                busy,
	output logic                done
);
	import tdpt_pkg::*;

	`include "trial_division_prime_test_macros.svh"

	tdpt_state_t state_q;
	tdpt_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_SCREEN;
			end
			ST_SCREEN: begin
				if (sts.n_lt2 || sts.n_eq2 || sts.n_even) state_nxt = ST_FINISH;
				else state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.last_step) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.d_gt_q || sts.rem_zero) state_nxt = ST_FINISH;
				else state_nxt = ST_DIV;
			end
			ST_FINISH: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCREEN: begin
				if (sts.n_lt2) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
				end else if (sts.n_eq2) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b1;
				end else if (sts.n_even) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
				end else begin
					cmd.div_init = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_CHECK: begin
				// bound test first: d > n/d means d*d > n
				if (sts.d_gt_q) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b1;
				end else if (sts.rem_zero) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
				end else begin
					cmd.next_div = 1'b1;
				end
			end
			ST_FINISH: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	`TDPT_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`TDPT_ASSERT_NEXT(a_done_one_cycle, clk, arst_n, done, !done && !busy, "result strobe longer than one cycle")
	`TDPT_ASSERT_NOW(a_done_while_busy, clk, arst_n, done, busy, "result strobe outside a test")
	`TDPT_ASSERT_NEXT(a_div_run_ends_in_check, clk, arst_n, state_q == ST_DIV && sts.last_step, state_q == ST_CHECK, "division run did not end in a check")

endmodule

// ===== src/trial_division_prime_test.sv =====
// Values below 3 and even values are settled in the screening state; any other value
// takes one division run and one check per odd divisor tried, from 3 upward.
// Throughput: one test at a time; the next beat is taken the cycle after done.
// The per-divisor cost is set by the shared restoring divider, one quotient bit a cycle.
// Reset (arst_n, async, active low) returns the controller to idle; no result is pending.
// The result beat is a one-cycle done strobe; the receiver cannot stall it.
`timescale 1ns / 1ps

module trial_division_prime_test #(
	parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] candidate,
	output logic             done,
	output logic             is_prime
);
	import tdpt_pkg::*;

	tdpt_cmd_t cmd;
	tdpt_sts_t sts;

	tdpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tdpt_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidate (candidate),
		.cmd       (cmd),
		.sts       (sts),
		.is_prime  (is_prime)
	);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for trial_division_prime_test: drives candidate beats, predicts
// the is_prime flag by trial division in a small scoreboard class and checks each done beat.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int CAND_W      = tdpt_pkg::DEF_WIDTH;
	localparam int RANDOM_ITEMS = 80;
	// slowest item used is a prime just below 2**20, which tries ~511 divisors
	localparam int STALL_LIMIT = 200_000;

	// Keeps the verdicts owed by the block, oldest first.
	class prime_verdicts;
		typedef struct {
			logic [CAND_W-1:0] candidate;
			bit                prime;
		} verdict_t;

		verdict_t owed[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		static function bit prime_by_trial(longint unsigned n);
			longint unsigned d;
			if (n < 2)
				return 1'b0;
			if (n == 2)
				return 1'b1;
			if (n[0] == 1'b0)
				return 1'b0;
			// d <= n/d keeps the bound free of overflow
			for (d = 3; d <= n / d; d += 2)
				if (n % d == 0)
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_candidate(logic [CAND_W-1:0] n);
			verdict_t v;
			v.candidate = n;
			v.prime     = prime_by_trial(longint'(n));
			owed.insert(owed.size(), v);
		endfunction

		function void check_verdict(logic got);
			verdict_t v;
			if (owed.size() == 0) begin
				$error("is_prime beat with no candidate pending: expected none, actual %0d", got);
				errors++;
				return;
			end
			v = owed.pop_front();
			if (got !== v.prime) begin
				$error("is_prime mismatch for candidate 0x%08h: expected %0d, actual %0d",
					v.candidate, v.prime, got);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CAND_W-1:0] candidate;
	logic              done;
	logic              is_prime;

	prime_verdicts verdicts = new();
	int            quiet_cycles = 0;

	trial_division_prime_test #(
		.WIDTH(CAND_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.candidate(candidate),
		.done     (done),
		.is_prime (is_prime)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Beats in both directions are taken at the rising edge; watchdog on quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				verdicts.check_verdict(is_prime);
			if (start && !busy)
				verdicts.note_candidate(candidate);
			if (done || (start && !busy)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	task automatic offer_candidate(input logic [CAND_W-1:0] n);
		@(negedge clk);
		start     <= 1'b1;
		candidate <= n;
		do @(posedge clk); while (busy);
	endtask

	task automatic rest_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start     <= 1'b0;
			candidate <= $urandom;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (verdicts.pending() != 0)
			@(negedge clk);
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// Mostly cheap values; wide ones carry a small factor so the run stays short.
	function automatic logic [CAND_W-1:0] pick_candidate();
		int          r;
		int unsigned p;
		int unsigned q;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom_range(0, 65535);
		if (r < 60)
			return $urandom_range(0, 1048575) | 1;
		if (r < 75)
			return 3 * $urandom_range(1, 32'h5555_5555);
		if (r < 90)
			return $urandom & ~32'd1;
		// odd composite whose smallest factor may be well above 3
		p = 2 * $urandom_range(1, 511) + 1;
		q = 2 * $urandom_range(1, 511) + 1;
		return p * q;
	endfunction

	logic [CAND_W-1:0] directed_values[$] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15, 32'd25,
		32'd49, 32'd121, 32'd169, 32'd65521, 32'd65535, 32'd65537,
		32'd1042441, 32'd1048573, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
		32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA
	};

	initial begin
		start     = 1'b0;
		candidate = '0;
		arst_n    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// edge values back to back, no idling
		foreach (directed_values[i])
			offer_candidate(directed_values[i]);
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			offer_candidate(pick_candidate());
			if (i == 40)
				hold_until_drained();
			else if (i < 55 || i >= 70)
				rest_sender(gap_length());
		end
		rest_sender(1);

		while (verdicts.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (verdicts.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/tdpt_pkg.sv
src/tdpt_dpath.sv
src/tdpt_ctrl.sv
src/trial_division_prime_test.sv
verif/tb_top.sv
